@@ src/etq_pkg.sv @@
// ----------------------------------------------------------------------------
// etq_pkg: shared types for the event time priority queue
// Result status codes, item mode codes and the per-cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package etq_pkg;

	// result status of one item
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// item mode codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic push;   // insert the new entry, chain shifts right past it
		logic pop;    // head leaves, chain shifts left
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ src/etq_cell.sv @@
// ----------------------------------------------------------------------------
// etq_cell: one slot of the sorted insertion chain
// Holds one entry, compares it with the broadcast key and takes the new
// entry, its left neighbor or its right neighbor as the command asks.
// ----------------------------------------------------------------------------
`default_nettype none

module etq_cell #(
	parameter int TIME_BITS = 32,
	parameter int TAG_BITS  = 16
) (
	input  wire                   clk,
	input  etq_pkg::cell_cmd_t    cmd,
	input  wire                   occ,        // slot holds a live entry
	input  wire [TIME_BITS-1:0]   new_time,
	input  wire [TAG_BITS-1:0]    new_tag,
	input  wire                   left_lt,    // left entry goes ahead of the new one
	input  wire [TIME_BITS-1:0]   left_time,
	input  wire [TAG_BITS-1:0]    left_tag,
	input  wire [TIME_BITS-1:0]   right_time,
	input  wire [TAG_BITS-1:0]    right_tag,
	output logic                  self_lt,    // own entry goes ahead of the new one
	output logic [TIME_BITS-1:0]  time_q,
	output logic [TAG_BITS-1:0]   tag_q
);
	import etq_pkg::*;

	// new entry lands behind every entry strictly earlier than it
	assign self_lt = occ && (time_q < new_time);

	// slot update: shift in from the left, take the new entry, or shift left
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!left_lt) begin
				time_q <= left_time;
				tag_q  <= left_tag;
			end else if (!self_lt) begin
				time_q <= new_time;
				tag_q  <= new_tag;
			end
		end else if (cmd.pop) begin
			time_q <= right_time;
			tag_q  <= right_tag;
		end
	end

endmodule

`default_nettype wire

@@ src/event_time_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// event_time_priority_queue_top: bounded event queue, earliest time first
// Sorted insertion queue built as a row of DEPTH cells.
// ----------------------------------------------------------------------------
// Every item is a push (time and tag) or a pop of the earliest entry, and
// yields one result. The entries sit in a chain of cells kept in time order,
// head in cell 0. On a push each cell compares its time with the new one in
// parallel and the chain opens a gap at the insertion point in the same
// cycle; among equal times the newest goes first. A pop shifts the chain one
// cell toward the head. The queue therefore takes one item per clock; its
// result shows in the output register on the next cycle and the input stalls
// only while that register holds a result that has not been taken. A push
// into a full queue reports full and drops the event; a pop from an empty
// queue reports empty.
`default_nettype none

module event_time_priority_queue_top #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32,
	parameter int TAG_BITS  = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                mode,
	input  wire  [31:0]        event_time,
	input  wire  [15:0]        event_tag,
	output logic               out_valid,
	input  wire                out_ready,
	output etq_pkg::status_t   status,
	output logic [31:0]        out_time,
	output logic [15:0]        out_tag,
	output logic [4:0]         fill_count
);
	import etq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [31:0]           out_time_q;
	logic [15:0]           out_tag_q;
	logic [CNT_W-1:0]      count_nxt;

	logic                  in_fire;
	logic                  is_full;
	logic                  is_empty;
	cell_cmd_t             cmd;
	logic [TIME_BITS-1:0]  key_time;
	logic [TAG_BITS-1:0]   key_tag;

	logic [TIME_BITS-1:0]  cell_time [DEPTH];
	logic [TAG_BITS-1:0]   cell_tag  [DEPTH];
	logic                  cell_lt   [DEPTH];
	logic                  cell_occ  [DEPTH];

	// handshake and broadcast command
	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign cmd.push = in_fire && (mode == MODE_PUSH) && !is_full;
	assign cmd.pop  = in_fire && (mode == MODE_POP) && !is_empty;
	assign key_time = TIME_BITS'(event_time);
	assign key_tag  = TAG_BITS'(event_tag);

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  l_lt;
		logic [TIME_BITS-1:0]  l_time;
		logic [TAG_BITS-1:0]   l_tag;
		logic [TIME_BITS-1:0]  r_time;
		logic [TAG_BITS-1:0]   r_tag;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign l_lt   = 1'b1;
			assign l_time = key_time;
			assign l_tag  = key_tag;
		end else begin : g_body
			assign l_lt   = cell_lt[i-1];
			assign l_time = cell_time[i-1];
			assign l_tag  = cell_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_time = cell_time[i];
			assign r_tag  = cell_tag[i];
		end else begin : g_inner
			assign r_time = cell_time[i+1];
			assign r_tag  = cell_tag[i+1];
		end

		etq_cell #(
			.TIME_BITS (TIME_BITS),
			.TAG_BITS  (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (cell_occ[i]),
			.new_time   (key_time),
			.new_tag    (key_tag),
			.left_lt    (l_lt),
			.left_time  (l_time),
			.left_tag   (l_tag),
			.right_time (r_time),
			.right_tag  (r_tag),
			.self_lt    (cell_lt[i]),
			.time_q     (cell_time[i]),
			.tag_q      (cell_tag[i])
		);
	end

	// fill count
	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (mode == MODE_PUSH) begin
				status_q   <= is_full ? ST_FULL : ST_DONE;
				out_time_q <= '0;
				out_tag_q  <= '0;
			end else if (is_empty) begin
				status_q   <= ST_EMPTY;
				out_time_q <= '0;
				out_tag_q  <= '0;
			end else begin
				status_q   <= ST_DONE;
				out_time_q <= 32'(cell_time[0]);
				out_tag_q  <= 16'(cell_tag[0]);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_time   = out_time_q;
	assign out_tag    = out_tag_q;
	assign fill_count = 5'(count_q);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (mode == MODE_PUSH) && is_full |=> out_valid_q && (status_q == ST_FULL)
			&& $stable(count_q))
		else $error("push into full queue not refused");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not shrink the queue");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_time[0] <= cell_time[1]))
		else $error("head entries out of order");

endmodule

`default_nettype wire

@@ sim/event_time_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_time_priority_queue_top_tb: self-checking bench for the event queue
// Drives push and pop transfers with random idling on both sides, predicts
// every result with a sorted-array copy of the queue and compares each
// output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module event_time_priority_queue_top_tb;
	import etq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int MAX_GAP      = 5;
	localparam int HOLD_CYCLES  = 60;
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASE_LEN    = 40;
	localparam int REPORT_LIMIT = 10;

	// one predicted output transfer
	typedef struct {
		status_t     status;
		logic [31:0] ev_time;
		logic [15:0] ev_tag;
		logic [4:0]  fill;
	} event_result_t;

	// sorted copy of the queue plus the list of results still owed by the block
	class event_queue_scoreboard;
		logic [31:0]   held_times[QUEUE_DEPTH];
		logic [15:0]   held_tags[QUEUE_DEPTH];
		int            held_count;
		event_result_t awaited[$];
		int            mismatches;

		function new();
			held_count = 0;
			mismatches = 0;
		endfunction

		// apply an accepted input to the sorted copy and queue its result
		function void note_item(logic m, logic [31:0] t, logic [15:0] g);
			event_result_t r;
			int pos;
			int k;
			r = '{ST_DONE, 32'd0, 16'd0, 5'd0};
			if (m == MODE_PUSH) begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new entry goes ahead of all entries with time >= its own
					pos = 0;
					while (pos < held_count && held_times[pos] < t)
						pos++;
					for (k = held_count; k > pos; k--) begin
						held_times[k] = held_times[k - 1];
						held_tags[k]  = held_tags[k - 1];
					end
					held_times[pos] = t;
					held_tags[pos]  = g;
					held_count++;
				end
			end else begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.ev_time = held_times[0];
					r.ev_tag  = held_tags[0];
					for (k = 1; k < held_count; k++) begin
						held_times[k - 1] = held_times[k];
						held_tags[k - 1]  = held_tags[k];
					end
					held_count--;
				end
			end
			r.fill = 5'(held_count);
			awaited.push_back(r);
		endfunction

		// compare one output transfer with the oldest prediction
		function void check_result(status_t st, logic [31:0] t, logic [15:0] g,
				logic [4:0] fc);
			event_result_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result status %0d time %h tag %h fill %0d",
						$realtime, st, t, g, fc);
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status || t !== e.ev_time || g !== e.ev_tag || fc !== e.fill) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$write("%0t: mismatch, expected status %0d time %h tag %h fill %0d,",
						$realtime, e.status, e.ev_time, e.ev_tag, e.fill);
					$display(" got status %0d time %h tag %h fill %0d", st, t, g, fc);
				end
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [31:0] event_time;
	logic [15:0] event_tag;
	logic        out_valid;
	logic        out_ready;
	status_t     status;
	logic [31:0] out_time;
	logic [15:0] out_tag;
	logic [4:0]  fill_count;

	event_queue_scoreboard sb;
	int sender_gap_max;
	int receiver_gap_max;
	bit hold_request;

	event_time_priority_queue_top #(
		.DEPTH     (QUEUE_DEPTH),
		.TIME_BITS (32),
		.TAG_BITS  (16)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.event_time (event_time),
		.event_tag  (event_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_time   (out_time),
		.out_tag    (out_tag),
		.fill_count (fill_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// transfer monitor: inputs are noted before outputs are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(mode, event_time, event_tag);
			if (out_valid && out_ready)
				sb.check_result(status, out_time, out_tag, fill_count);
		end
	end

	// offer one item after a random gap and hold it until the transfer
	task automatic send_item(input logic m, input logic [31:0] t, input logic [15:0] g);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		event_time <= t;
		event_tag  <= g;
		do @(posedge clk); while (!in_ready);
	endtask

	// random item; times often collide or sit near the top of the range
	task automatic send_random(input int push_pct);
		logic        m;
		logic [31:0] t;
		case ($urandom_range(0, 3))
			0: begin
				t = $urandom_range(0, 7);
			end
			1: begin
				t = 32'hFFFF_FFF8 | $urandom_range(0, 7);
			end
			default: begin
				t = $urandom;
			end
		endcase
		m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
		send_item(m, t, 16'($urandom));
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = $urandom_range(0, receiver_gap_max);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int n;
		int push_pct;
		clk              = 1'b0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		mode             = MODE_PUSH;
		event_time       = 32'd0;
		event_tag        = 16'd0;
		out_ready        = 1'b0;
		sender_gap_max   = 0;
		receiver_gap_max = 0;
		hold_request     = 1'b0;
		push_pct         = 50;
		sb = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop from empty, fill with extremes and equal times, push when full, then pop five
		send_item(MODE_POP, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(MODE_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(MODE_PUSH, 32'd0, 16'h0000);
		send_item(MODE_PUSH, 32'd7, 16'h0001);
		send_item(MODE_PUSH, 32'd7, 16'h0002);
		send_item(MODE_PUSH, 32'hFFFF_FFFF, 16'h0003);
		for (n = 0; n < QUEUE_DEPTH - 5; n++)
			send_item(MODE_PUSH, 32'h1000 * (n % 3), 16'h0100 + 16'(n));
		send_item(MODE_PUSH, 32'd0, 16'hBEEF);
		for (n = 0; n < 5; n++)
			send_item(MODE_POP, 32'd0, 16'd0);

		// random phases that push toward full, drain toward empty, or hover
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 50;
				endcase
				sender_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
				receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			end
			// back-pressure: receiver holds off while items keep coming
			if (n == 200 || n == 560) begin
				sender_gap_max = 0;
				hold_request   = 1'b1;
			end
			send_random(push_pct);
		end
		in_valid <= 1'b0;

		// drain the outstanding results
		n = 0;
		while (sb.pending() != 0 && n < 1000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS event_time_priority_queue_top");
		else
			$display("FAIL event_time_priority_queue_top");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#2_000_000;
		$display("FAIL event_time_priority_queue_top");
		$finish;
	end

endmodule
